// ===== rtl/core/gbr_pkg.sv =====
package gbr_pkg;

    // Bits unpacked from one bitmap word
    localparam int BYTE_BITS = 8;
    localparam int LEFT_W    = $clog2(BYTE_BITS + 1);

    // Configuration port layout
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int COLOR_W = 16;
    localparam logic [0:0] REG_DRAW_COLOR = 1'b0;

    // Input word, first field in the top bits
    typedef struct packed {
        logic [7:0] bitmap_byte;
        logic       glyph_start;
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [7:0] glyph_width;
        logic [7:0] glyph_height;
    } t_gbr_in;

    // Pixel write word
    typedef struct packed {
        logic [6:0]         pixel_x;
        logic [6:0]         pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_of_byte;
    } t_gbr_out;

    // Classified command handed from front to back
    typedef struct packed {
        logic [7:0] bits;
        logic       start;
        logic       empty;
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic [7:0] w_last;
        logic [7:0] h_last;
    } t_gbr_cmd;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } t_gbr_qstat;

endpackage

// ===== rtl/core/glyph_bitmap_rasterizer_core.sv =====
// Glyph bitmap rasterizer. Each input word carries one packed 1-bpp bitmap
// byte, unpacked MSB first across the glyph's width-by-height walk; every set
// bit inside the glyph becomes one pixel write at the origin plus column/row
// (mod 256, clamped to the display), in the color from register draw_color
// (APB address 0). The back end unpacks one bit per clock while the output
// register is free, whether a byte yields zero or eight writes; a byte that
// finishes its glyph stops at that bit, and a byte that lands after the glyph
// end or belongs to an empty glyph is retired at its first bit step. The output
// register takes one write per cycle while not stalled. Input words pass a
// two-entry queue, so up to two words can wait while pixel writes are stalled.
// The last_of_byte flag of a write is known only at the next set bit or at the
// end of its byte, so each write is held back until then.
module glyph_bitmap_rasterizer_core #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  gbr_pkg::t_gbr_in            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output gbr_pkg::t_gbr_out           o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbr_pkg::PADDR_W-1:0] paddr,
    input  logic [gbr_pkg::PDATA_W-1:0] pwdata,
    output logic [gbr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import gbr_pkg::*;

    logic [COLOR_W-1:0] r_draw_color;
    logic               push;
    t_gbr_cmd           push_data;
    t_gbr_cmd           head;
    t_gbr_qstat         qstat;
    logic               pop;

    // Register file: write on the access phase, read back the color
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1] == REG_DRAW_COLOR)) begin
            r_draw_color <= pwdata[COLOR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_DRAW_COLOR) begin
            prdata = {{(PDATA_W-COLOR_W){1'b0}}, r_draw_color};
        end
    end

    // Front: accept and classify words
    gbr_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Queue between front and back
    gbr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_qstat     (qstat)
    );

    // Back: walk the glyph and issue pixel writes
    gbr_back #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_valid (qstat.valid),
        .i_fifo_head  (head),
        .o_pop        (pop),
        .i_draw_color (r_draw_color),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== rtl/core/gbr_front.sv =====
module gbr_front (
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gbr_pkg::t_gbr_in  i_in_data,
    input  gbr_pkg::t_gbr_qstat i_qstat,
    output logic              o_push,
    output gbr_pkg::t_gbr_cmd o_push_data
);
    import gbr_pkg::*;

    // Hold the input off while the queue is full
    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    // Classify the word: flag empty glyphs, precompute last column and row
    always_comb begin
        o_push_data.bits     = i_in_data.bitmap_byte;
        o_push_data.start    = i_in_data.glyph_start;
        o_push_data.empty    = (i_in_data.glyph_width == 8'd0) ||
                               (i_in_data.glyph_height == 8'd0);
        o_push_data.origin_x = i_in_data.origin_x;
        o_push_data.origin_y = i_in_data.origin_y;
        o_push_data.w_last   = i_in_data.glyph_width - 8'd1;
        o_push_data.h_last   = i_in_data.glyph_height - 8'd1;
    end

endmodule

// ===== rtl/core/gbr_fifo.sv =====
module gbr_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gbr_pkg::t_gbr_cmd   i_push_data,
    input  logic                i_pop,
    output gbr_pkg::t_gbr_cmd   o_head,
    output gbr_pkg::t_gbr_qstat o_qstat
);
    import gbr_pkg::*;

    t_gbr_cmd   r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.valid = (r_cnt != 2'd0);
    assign o_head        = r_mem[r_rd];

    // Track occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/core/gbr_back.sv =====
module gbr_back #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fifo_valid,
    input  gbr_pkg::t_gbr_cmd           i_fifo_head,
    output logic                        o_pop,
    input  logic [gbr_pkg::COLOR_W-1:0] i_draw_color,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output gbr_pkg::t_gbr_out           o_out_data
);
    import gbr_pkg::*;

    localparam logic [8:0] X_LIM = 9'(DISPLAY_WIDTH);
    localparam logic [8:0] X_MAX = 9'(DISPLAY_WIDTH - 1);
    localparam logic [8:0] Y_LIM = 9'(DISPLAY_HEIGHT);
    localparam logic [8:0] Y_MAX = 9'(DISPLAY_HEIGHT - 1);

    // Current word and glyph walk state
    t_gbr_cmd          r_cur, n_cur;
    logic              r_cur_valid, n_cur_valid;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [7:0]        r_col, n_col;
    logic [7:0]        r_row, n_row;
    logic              r_done, n_done;

    // One pixel held back until it is known whether it ends its word
    logic              r_pend_valid, n_pend_valid;
    logic              r_pend_last, n_pend_last;
    logic [6:0]        r_pend_x, n_pend_x;
    logic [6:0]        r_pend_y, n_pend_y;

    // Output register
    logic              r_out_valid, n_out_valid;
    t_gbr_out          r_out, n_out;

    logic       out_free;
    logic       step;
    logic       skip;
    logic       emit;
    logic       col_wrap;
    logic       row_wrap;
    logic       byte_end;
    logic       load;
    logic       out_now;
    logic [7:0] sum_x;
    logic [7:0] sum_y;
    logic [6:0] pix_x;
    logic [6:0] pix_y;

    // Decide what the walk does this cycle
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        step     = r_cur_valid && out_free;
        skip     = r_cur.empty || r_done;
        emit     = step && !skip && r_cur.bits[BYTE_BITS-1];
        col_wrap = (r_col >= r_cur.w_last);
        row_wrap = (r_row >= r_cur.h_last);
        byte_end = step && (skip || (col_wrap && row_wrap) ||
                            (r_left == LEFT_W'(1)));
        load     = out_free && i_fifo_valid && (!r_cur_valid || byte_end);
        out_now  = out_free && r_pend_valid && (r_pend_last || emit || byte_end);
    end

    assign o_pop = load;

    // Clamp the glyph coordinate to the display
    always_comb begin
        sum_x = r_cur.origin_x + r_col;
        sum_y = r_cur.origin_y + r_row;
        pix_x = ({1'b0, sum_x} >= X_LIM) ? X_MAX[6:0] : sum_x[6:0];
        pix_y = ({1'b0, sum_y} >= Y_LIM) ? Y_MAX[6:0] : sum_y[6:0];
    end

    // Next state of the walk and the current word
    always_comb begin
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_left      = r_left;
        n_col       = r_col;
        n_row       = r_row;
        n_done      = r_done;
        if (step) begin
            n_cur.bits = {r_cur.bits[BYTE_BITS-2:0], 1'b0};
            n_left     = r_left - LEFT_W'(1);
            if (skip) begin
                if (r_cur.empty) begin
                    n_done = 1'b1;
                end
            end else if (col_wrap) begin
                n_col = 8'd0;
                if (row_wrap) begin
                    n_row  = 8'd0;
                    n_done = 1'b1;
                end else begin
                    n_row = r_row + 8'd1;
                end
            end else begin
                n_col = r_col + 8'd1;
            end
            if (byte_end) begin
                n_cur_valid = 1'b0;
            end
        end
        // Take the next word; a start flag clears the walk first
        if (load) begin
            n_cur       = i_fifo_head;
            n_cur_valid = 1'b1;
            n_left      = LEFT_W'(BYTE_BITS);
            if (i_fifo_head.start) begin
                n_col  = 8'd0;
                n_row  = 8'd0;
                n_done = 1'b0;
            end
        end
    end

    // Next state of the held pixel and the output register
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_last  = r_pend_last;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        if (emit) begin
            n_pend_valid = 1'b1;
            n_pend_last  = byte_end;
            n_pend_x     = pix_x;
            n_pend_y     = pix_y;
        end else if (out_now) begin
            n_pend_valid = 1'b0;
        end
        if (out_free) begin
            n_out_valid       = out_now;
            n_out.pixel_x     = r_pend_x;
            n_out.pixel_y     = r_pend_y;
            n_out.pixel_color = i_draw_color;
            n_out.last_of_byte = r_pend_last || !emit;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid  <= 1'b0;
            r_left       <= '0;
            r_col        <= 8'd0;
            r_row        <= 8'd0;
            r_done       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cur_valid  <= n_cur_valid;
            r_left       <= n_left;
            r_col        <= n_col;
            r_row        <= n_row;
            r_done       <= n_done;
            r_pend_valid <= n_pend_valid;
            r_pend_last  <= n_pend_last;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_pend_x <= n_pend_x;
        r_pend_y <= n_pend_y;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A word in work has between one and eight bits left
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_left != '0) && (r_left <= LEFT_W'(BYTE_BITS)))
        else $error("bit count out of range");

    // A held pixel that closes its word leaves at once when the output is free
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_pend_last && !r_out_valid)
            |=> (r_out_valid && r_out.last_of_byte))
        else $error("closing pixel not flushed");

    // A new pixel of the same word pushes the held one out as not last
    a_mid_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_pend_valid && !r_pend_last)
            |=> (r_out_valid && !r_out.last_of_byte))
        else $error("middle pixel marked last");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gbr_pkg::*;

    localparam int DISP_W      = 128;
    localparam int DISP_H      = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam logic [PADDR_W-1:0] COLOR_ADDR = PADDR_W'(4 * int'(REG_DRAW_COLOR));

    // One directed stimulus row, optionally with its single expected write typed in
    typedef struct {
        t_gbr_in  word;
        bit       typed;
        int       n_px;
        t_gbr_out px;
    } t_dir_row;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_gbr_in              in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_gbr_out             out_data;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Predicted rasterizer state
    logic [COLOR_W-1:0]   ink_color  = '0;
    logic [7:0]           col_pos    = '0;
    logic [7:0]           row_pos    = '0;
    bit                   glyph_over = 1'b0;
    bit                   byte_live;
    t_gbr_out             step_px [8];
    t_gbr_out             px_expected [$];

    t_dir_row             dir_rows [$];
    int                   mismatches  = 0;
    int                   cycle_count = 0;
    int                   live_count  = 0;
    bit                   calm        = 1'b0;

    glyph_bitmap_rasterizer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Clamp origin plus offset (mod 256) onto the display
    function automatic logic [6:0] screen_coord(input logic [7:0] base, input logic [7:0] offs,
                                                input int limit);
        logic [7:0] sum;
        sum = base + offs;
        if (int'(sum) >= limit) sum = 8'(limit - 1);
        return sum[6:0];
    endfunction

    // Walk one bitmap byte MSB first; fill step_px and return the write count
    function automatic int rasterize_byte(input t_gbr_in w);
        int n;
        n = 0;
        byte_live = 1'b0;
        if (w.glyph_start) begin
            col_pos    = '0;
            row_pos    = '0;
            glyph_over = 1'b0;
        end
        for (int b = 7; b >= 0; b--) begin
            if (w.glyph_width == 8'd0 || w.glyph_height == 8'd0) glyph_over = 1'b1;
            if (!glyph_over) begin
                byte_live = 1'b1;
                if (w.bitmap_byte[b]) begin
                    step_px[n].pixel_x      = screen_coord(w.origin_x, col_pos, DISP_W);
                    step_px[n].pixel_y      = screen_coord(w.origin_y, row_pos, DISP_H);
                    step_px[n].pixel_color  = ink_color;
                    step_px[n].last_of_byte = 1'b0;
                    n++;
                end
                if (int'(col_pos) + 1 >= int'(w.glyph_width)) begin
                    col_pos = '0;
                    if (int'(row_pos) + 1 >= int'(w.glyph_height)) begin
                        row_pos    = '0;
                        glyph_over = 1'b1;
                    end else begin
                        row_pos = row_pos + 8'd1;
                    end
                end else begin
                    col_pos = col_pos + 8'd1;
                end
            end
        end
        if (n > 0) step_px[n-1].last_of_byte = 1'b1;
        return n;
    endfunction

    function automatic t_dir_row mk_row(input logic [7:0] bits, input logic start,
                                        input logic [7:0] ox, input logic [7:0] oy,
                                        input logic [7:0] gw, input logic [7:0] gh,
                                        input bit typed, input int n_px,
                                        input logic [6:0] px_x, input logic [6:0] px_y);
        t_dir_row r;
        r.word.bitmap_byte     = bits;
        r.word.glyph_start     = start;
        r.word.origin_x        = ox;
        r.word.origin_y        = oy;
        r.word.glyph_width     = gw;
        r.word.glyph_height    = gh;
        r.typed                = typed;
        r.n_px                 = n_px;
        r.px.pixel_x           = px_x;
        r.px.pixel_y           = px_y;
        r.px.pixel_color       = 16'h0000;
        r.px.last_of_byte      = 1'b1;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // Hold the word until accepted, then record what it should draw
    task automatic send_word(input t_gbr_in w, input bit typed, input int n_typed,
                             input t_gbr_out typed_px);
        int n;
        in_data  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        n = rasterize_byte(w);
        if (typed) begin
            if (n_typed == 1) px_expected.push_back(typed_px);
        end else begin
            for (int k = 0; k < n; k++) px_expected.push_back(step_px[k]);
        end
    endtask

    // Drop valid now and then for a random idle gap, unless calm
    task automatic maybe_idle();
        int gap;
        if (!calm && $urandom_range(0, 99) < 26) begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending, let every expected write arrive, then let the pipe settle
    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (px_expected.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == COLOR_ADDR) ink_color = data[COLOR_W-1:0];
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
            note_mismatch($sformatf("register read exp %h got %h", want, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_color(input logic [COLOR_W-1:0] c);
        apb_write(COLOR_ADDR, PDATA_W'(c));
        apb_check(COLOR_ADDR, PDATA_W'(c));
    endtask

    // One random glyph: mostly well formed, some truncated, overrun or corrupted
    task automatic draw_glyph();
        t_gbr_in w;
        t_gbr_in cur;
        int kind;
        int nbytes;
        int extra;
        kind       = $urandom_range(0, 99);
        w          = '0;
        w.origin_x = 8'($urandom);
        w.origin_y = 8'($urandom);
        if (kind < 80) begin
            w.glyph_width  = 8'($urandom_range(1, 12));
            w.glyph_height = 8'($urandom_range(1, 12));
        end else if (kind < 88) begin
            w.glyph_width  = 8'($urandom_range(128, 255));
            w.glyph_height = 8'($urandom_range(1, 2));
        end else begin
            w.glyph_width  = 8'($urandom_range(0, 255));
            w.glyph_height = 8'($urandom_range(0, 255));
        end
        nbytes = (int'(w.glyph_width) * int'(w.glyph_height) + 7) / 8;
        if (nbytes > 40) nbytes = $urandom_range(1, 40);
        if (nbytes == 0) nbytes = 1;
        extra = ($urandom_range(0, 99) < 10) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < nbytes + extra; i++) begin
            cur             = w;
            cur.glyph_start = (i == 0);
            case ($urandom_range(0, 7))
                0:       cur.bitmap_byte = 8'hFF;
                1:       cur.bitmap_byte = 8'h00;
                default: cur.bitmap_byte = 8'($urandom);
            endcase
            if ($urandom_range(0, 99) < 4) begin
                cur.glyph_width  = 8'($urandom);
                cur.glyph_height = 8'($urandom);
                cur.glyph_start  = 1'($urandom);
            end
            maybe_idle();
            send_word(cur, 1'b0, 0, '0);
            if (byte_live) live_count++;
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    // Compare each accepted pixel write with the oldest expectation
    always @(posedge clk) begin
        t_gbr_out exp_px;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (px_expected.size() == 0) begin
                note_mismatch($sformatf("unexpected write x=%0d y=%0d c=%h l=%b",
                              out_data.pixel_x, out_data.pixel_y,
                              out_data.pixel_color, out_data.last_of_byte));
            end else begin
                exp_px = px_expected.pop_front();
                if (out_data.pixel_x !== exp_px.pixel_x ||
                    out_data.pixel_y !== exp_px.pixel_y ||
                    out_data.pixel_color !== exp_px.pixel_color ||
                    out_data.last_of_byte !== exp_px.last_of_byte)
                    note_mismatch($sformatf(
                        "exp x=%0d y=%0d c=%h l=%b got x=%0d y=%0d c=%h l=%b",
                        exp_px.pixel_x, exp_px.pixel_y, exp_px.pixel_color,
                        exp_px.last_of_byte, out_data.pixel_x, out_data.pixel_y,
                        out_data.pixel_color, out_data.last_of_byte));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [COLOR_W-1:0] phase_color [4];
        int                 target;

        // Directed rows: typed where the result is obvious, else predicted
        // after reset with no start flag: the walk begins at column zero
        dir_rows.push_back(mk_row(8'h80, 1'b0, 8'h00, 8'h00, 8'd8, 8'd2, 1, 1, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'h3C, 1'b0, 8'h00, 8'h00, 8'd8, 8'd2, 0, 0, 7'd0, 7'd0));
        // finished glyph ignores further bytes
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 8'h00, 8'h00, 8'd8, 8'd2, 1, 0, 7'd0, 7'd0));
        // empty glyphs
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 8'h00, 8'h00, 8'd0, 8'd5, 1, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 8'h00, 8'h00, 8'd255, 8'd0, 1, 0, 7'd0, 7'd0));
        // clamp at both extremes, wrap past 255
        dir_rows.push_back(mk_row(8'h80, 1'b1, 8'hFF, 8'hFF, 8'd1, 8'd1, 1, 1, 7'd127, 7'd127));
        dir_rows.push_back(mk_row(8'h40, 1'b1, 8'hFF, 8'h00, 8'd8, 8'd1, 1, 1, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'h80, 1'b1, 8'h7F, 8'h80, 8'd2, 8'd2, 1, 1, 7'd127, 7'd127));
        // full rows, then a continuation
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 8'h0A, 8'h14, 8'd8, 8'd8, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'hAA, 1'b0, 8'h0A, 8'h14, 8'd8, 8'd8, 0, 0, 7'd0, 7'd0));
        // width shrinks below the column, then height below the row
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 8'h30, 8'h40, 8'd5, 8'd4, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 8'h30, 8'h40, 8'd2, 8'd4, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 8'h30, 8'h40, 8'd5, 8'd1, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'h00, 1'b1, 8'h11, 8'h22, 8'd8, 8'd8, 0, 0, 7'd0, 7'd0));
        // widest glyph
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 8'h80, 8'h7E, 8'd255, 8'd255, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'h55, 1'b0, 8'h80, 8'h7E, 8'd255, 8'd255, 0, 0, 7'd0, 7'd0));
        // bits past the glyph end are dropped
        dir_rows.push_back(mk_row(8'hFF, 1'b1, 8'h7C, 8'h7D, 8'd3, 8'd1, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 8'h7C, 8'h7D, 8'd3, 8'd1, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'h81, 1'b1, 8'hF8, 8'hF9, 8'd128, 8'd1, 0, 0, 7'd0, 7'd0));
        // restart in the middle of a glyph
        dir_rows.push_back(mk_row(8'hC3, 1'b1, 8'h01, 8'h02, 8'd4, 8'd4, 0, 0, 7'd0, 7'd0));
        dir_rows.push_back(mk_row(8'hE7, 1'b1, 8'h01, 8'h02, 8'd4, 8'd4, 0, 0, 7'd0, 7'd0));

        phase_color[0] = 16'hFFFF;
        phase_color[1] = 16'h0000;
        phase_color[2] = 16'($urandom);
        phase_color[3] = 16'($urandom);

        // Reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset color
        foreach (dir_rows[i]) begin
            maybe_idle();
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].n_px, dir_rows[i].px);
        end

        // Random phases, each at its own color; the second runs without idling
        target = 0;
        for (int ph = 0; ph < 4; ph++) begin
            drain_pixels();
            set_color(phase_color[ph]);
            calm   = (ph == 1);
            target = target + 70;
            while (live_count < target) draw_glyph();
        end
        calm = 1'b0;

        drain_pixels();
        if (mismatches == 0 && px_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
